// ===== sv/hedr_pkg.sv =====
package hedr_pkg;

    localparam int NUM_STATES  = 16;
    localparam int NUM_SYMBOLS = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int SUM_BITS    = 40;
    localparam int THRESH_BITS = 40;
    localparam int CMD_BITS    = 2;
    localparam int STATE_BITS  = 4;
    localparam int SYMBOL_BITS = 4;
    localparam int WEIGHT_W    = 16;
    localparam int PROB_BITS   = 17;
    localparam int ENTRIES     = NUM_STATES * NUM_SYMBOLS;
    localparam int ADDR_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ST_ADDR_BITS = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int SYM_ADDR_BITS = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int DIV_STEPS   = 17;
    localparam int DIV_CNT_BITS = 5;
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ACCUM = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_BAD   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [ADDR_BITS-1:0]    addr;
        logic [ST_ADDR_BITS-1:0] st;
        logic [WEIGHT_BITS-1:0]  weight;
    } job_t;

    typedef struct packed {
        logic push;
        logic full;
        logic empty;
        logic pop;
    } qctl_t;

endpackage

// ===== sv/hedr_ram.sv =====
module hedr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [ABITS-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [ABITS-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/hedr_front.sv =====
module hedr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [hedr_pkg::CMD_BITS-1:0]  cmd,
    input  logic [hedr_pkg::STATE_BITS-1:0] state_index,
    input  logic [hedr_pkg::SYMBOL_BITS-1:0] symbol,
    input  logic [hedr_pkg::WEIGHT_W-1:0]  weight,
    input  logic                           pop,
    output hedr_pkg::job_t                 head,
    output hedr_pkg::qctl_t                qctl
);
    import hedr_pkg::*;

    job_t            q_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wp_reg, rp_reg;
    logic [QPTR_BITS:0]   cnt_reg;
    job_t            job;
    logic            valid_idx;
    logic            push;

    always_comb
    begin
        valid_idx = (32'(state_index) < NUM_STATES) && (32'(symbol) < NUM_SYMBOLS);
        job.st     = ST_ADDR_BITS'(state_index);
        job.addr   = ADDR_BITS'(state_index) * ADDR_BITS'(NUM_SYMBOLS)
                     + ADDR_BITS'(symbol);
        job.weight = WEIGHT_BITS'(weight);
        unique case (cmd_t'(cmd))
            CMD_ACCUM: job.op = valid_idx ? OP_ACCUM : OP_BAD;
            CMD_CLEAR: job.op = OP_CLEAR;
            CMD_READ:  job.op = valid_idx ? OP_READ : OP_BAD;
            default:   job.op = OP_BAD;
        endcase
    end

    assign qctl.full  = (cnt_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign qctl.empty = (cnt_reg == '0);
    assign push       = start && !qctl.full
                        && !(job.op == OP_BAD && cmd_t'(cmd) != CMD_READ);
    assign qctl.push  = push;
    assign qctl.pop   = pop;
    assign head       = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
        end
    end
endmodule

// ===== sv/hedr_back.sv =====
module hedr_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hedr_pkg::job_t                     head,
    input  hedr_pkg::qctl_t                    qctl,
    input  logic [hedr_pkg::THRESH_BITS-1:0]   thresh,
    output logic                               pop,
    output logic                               done,
    output logic [hedr_pkg::PROB_BITS-1:0]     probability,
    output logic                               state_unused
);
    import hedr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_WRITE = 6'b000100,
        S_CLEAR = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    job_t   job_reg;
    logic [ENTRIES-1:0]      sv_reg;
    logic [NUM_STATES-1:0]   tv_reg;
    logic [SUM_BITS-1:0]     rd_sym, rd_st, cnt_v, tot_v;
    logic [SUM_BITS:0]       rem_reg, rem_sh, add_s, add_t;
    logic [SUM_BITS-1:0]     den_reg;
    logic [PROB_BITS:0]      q_reg;
    logic [DIV_CNT_BITS-1:0] dcnt_reg;
    logic                    sym_we, st_we;
    logic [SUM_BITS-1:0]     sym_wd, st_wd;
    logic [ADDR_BITS-1:0]    sym_ra;
    logic [ST_ADDR_BITS-1:0] st_ra;
    logic [PROB_BITS-1:0]    prob_reg;
    logic                    unused_reg, done_reg;

    // hold the read address on the current request so the write sees its own data
    assign sym_ra = (state_reg == S_IDLE) ? head.addr : job_reg.addr;
    assign st_ra  = (state_reg == S_IDLE) ? head.st : job_reg.st;

    hedr_ram #(.WIDTH(SUM_BITS), .DEPTH(ENTRIES)) u_sym (
        .clk(clk), .we(sym_we), .waddr(job_reg.addr), .wdata(sym_wd),
        .raddr(sym_ra), .rdata(rd_sym)
    );
    hedr_ram #(.WIDTH(SUM_BITS), .DEPTH(NUM_STATES)) u_st (
        .clk(clk), .we(st_we), .waddr(job_reg.st), .wdata(st_wd),
        .raddr(st_ra), .rdata(rd_st)
    );

    assign cnt_v = sv_reg[job_reg.addr] ? rd_sym : '0;
    assign tot_v = tv_reg[job_reg.st] ? rd_st : '0;
    assign add_s = {1'b0, cnt_v} + (SUM_BITS+1)'(job_reg.weight);
    assign add_t = {1'b0, tot_v} + (SUM_BITS+1)'(job_reg.weight);
    assign sym_wd = add_s[SUM_BITS] ? SUM_MAX : add_s[SUM_BITS-1:0];
    assign st_wd  = add_t[SUM_BITS] ? SUM_MAX : add_t[SUM_BITS-1:0];
    assign sym_we = (state_reg == S_WRITE);
    assign st_we  = (state_reg == S_WRITE);
    assign rem_sh = {rem_reg[SUM_BITS-1:0], 1'b0};

    assign pop  = (state_reg == S_IDLE) && !qctl.empty;
    assign done = done_reg;
    assign probability  = prob_reg;
    assign state_unused = unused_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (pop) state_next = (head.op == OP_CLEAR) ? S_CLEAR : S_FETCH;
            S_FETCH:
            begin
                if (job_reg.op == OP_ACCUM)
                    state_next = S_WRITE;
                else if (job_reg.op == OP_READ && tot_v > thresh)
                    state_next = S_DIV;
                else
                    state_next = S_OUT;
            end
            S_WRITE: state_next = S_IDLE;
            S_CLEAR: state_next = S_IDLE;
            S_DIV:   if (dcnt_reg == DIV_CNT_BITS'(DIV_STEPS)) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (state_reg == S_FETCH)
        begin
            den_reg  <= tot_v;
            rem_reg  <= (cnt_v >= tot_v) ? (SUM_BITS+1)'(0) : {1'b0, cnt_v};
            q_reg    <= (cnt_v >= tot_v) ? (PROB_BITS+1)'(1) : '0;
            dcnt_reg <= '0;
        end
        else if (state_reg == S_DIV && dcnt_reg != DIV_CNT_BITS'(DIV_STEPS))
        begin
            dcnt_reg <= dcnt_reg + DIV_CNT_BITS'(1);
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                q_reg   <= {q_reg[PROB_BITS-1:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[PROB_BITS-1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sv_reg     <= '0;
            tv_reg     <= '0;
            done_reg   <= 1'b0;
            prob_reg   <= '0;
            unused_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == S_CLEAR)
            begin
                sv_reg <= '0;
                tv_reg <= '0;
            end
            if (state_reg == S_WRITE)
            begin
                sv_reg[job_reg.addr] <= 1'b1;
                tv_reg[job_reg.st]   <= 1'b1;
            end
            if (state_reg == S_FETCH && state_next == S_OUT)
            begin
                done_reg   <= 1'b1;
                prob_reg   <= '0;
                unused_reg <= 1'b1;
            end
            if (state_reg == S_DIV && state_next == S_OUT)
            begin
                done_reg   <= 1'b1;
                prob_reg   <= PROB_BITS'((q_reg + (PROB_BITS+1)'(1)) >> 1);
                unused_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== sv/hmm_discrete_emission_reestimate_core.sv =====
// Discrete-emission HMM reestimation core (emission M-step).
// Request channel: pulse start with cmd, state_index, symbol, weight while
// busy is low. cmd 0 accumulates weight into the state total and the
// state/symbol count, cmd 1 clears all sums, cmd 2 reads count/total as
// Q1.16 rounded, or zero with state_unused set when the total is not above
// den_threshold. cmd 3 and out-of-range accumulates are dropped.
// Results: one per read, shown for one cycle with done high; the receiver
// cannot stall, so results are never held.
// A two-entry queue decouples request intake from execution; busy rises
// only when it is full.
// Steps: accumulate is pop, read, write; clear is pop, clear; a read
// with unused total is pop, read, done; a read with division runs the
// 17-step restoring divider, which sets read throughput.
// Reset clears every sum at once through per-entry valid bits and sets
// den_threshold to zero; configuration is written through cfg_we/cfg_data.
module hmm_discrete_emission_reestimate_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [hedr_pkg::CMD_BITS-1:0]     cmd,
    input  logic [hedr_pkg::STATE_BITS-1:0]   state_index,
    input  logic [hedr_pkg::SYMBOL_BITS-1:0]  symbol,
    input  logic [hedr_pkg::WEIGHT_W-1:0]     weight,
    input  logic                              cfg_we,
    input  logic [hedr_pkg::THRESH_BITS-1:0]  cfg_data,
    output logic                              done,
    output logic [hedr_pkg::PROB_BITS-1:0]    probability,
    output logic                              state_unused
);
    import hedr_pkg::*;

    job_t  head;
    qctl_t qctl;
    logic  pop;
    logic [THRESH_BITS-1:0] thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= '0;
        end
        else if (cfg_we)
        begin
            thresh_reg <= cfg_data;
        end
    end

    assign busy = qctl.full;

    hedr_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .state_index(state_index), .symbol(symbol), .weight(weight),
        .pop(pop), .head(head), .qctl(qctl)
    );

    hedr_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .qctl(qctl),
        .thresh(thresh_reg), .pop(pop), .done(done),
        .probability(probability), .state_unused(state_unused)
    );
endmodule

// ===== sv/hedr_check.sv =====
module hedr_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [hedr_pkg::PROB_BITS-1:0]    probability,
    input logic                              state_unused
);
    import hedr_pkg::*;

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && state_unused |-> probability == '0)
        else $error("unused state with nonzero probability");
    a_prob_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> probability <= PROB_BITS'(65536))
        else $error("probability above one");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");
    a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start) && !start && $past(!busy) |-> !busy)
        else $error("busy without requests");
endmodule

bind hmm_discrete_emission_reestimate_core hedr_check u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .probability(probability), .state_unused(state_unused)
);
